/* rtl/linear_probe_hash_set_top_defines.svh */
// assertion macros shared by the checker of the linear probe hash set
// no dependencies
`ifndef LINEAR_PROBE_HASH_SET_TOP_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_TOP_DEFINES_SVH

// same-cycle implication
`define LPHS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lphs check failed");

// next-cycle implication
`define LPHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lphs check failed");

`endif

/* rtl/lphs_pkg.sv */
// types, constants and helpers of the linear probe hash set
// no dependencies
package lphs_pkg;

  localparam int SLOTS       = 26;
  localparam int SLOT_W      = 5;
  localparam int MAX_LETTERS = 10;
  localparam int LETTER_W    = 5;
  localparam int LETTERS_W   = 50;
  localparam int LEN_W       = 4;
  localparam int KEY_W       = LETTERS_W + LEN_W;
  localparam int WORD_W      = KEY_W + 2;

  typedef enum logic [1:0] {
    ST_NEVER    = 2'd0,
    ST_OCCUPIED = 2'd1,
    ST_TOMB     = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OUT_ADDED    = 3'd0,
    OUT_PRESENT  = 3'd1,
    OUT_DELETED  = 3'd2,
    OUT_NOTFOUND = 3'd3,
    OUT_FULL     = 3'd4
  } outcome_t;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_DEL = 1'b1;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    next_slot = (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

/* rtl/lphs_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/linear_probe_hash_set_top.sv */
// Linear-probing hash set of up to 26 short lowercase keys. Each transfer on the
// input carries a key and an add or delete action and yields one result transfer
// with the outcome and the slot involved. An item is handled in steps: the key is
// taken, the probe runs from the home slot up to all 26 slots with one slot memory
// read per cycle through the registered read port, and the result is written back
// and posted. Slot status is cleared at reset through per-slot valid flops, so the
// block is ready in the cycle after reset. The result register lets the next item
// be taken while a result still waits.
// depends on lphs_pkg and lphs_ram
module linear_probe_hash_set_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic [lphs_pkg::LETTERS_W-1:0]  key_letters,
  input  logic [lphs_pkg::LEN_W-1:0]      key_length,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      outcome,
  output logic [lphs_pkg::SLOT_W-1:0]     slot_index
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_EMIT
  } state_t;

  state_t                              state;
  logic                                act;
  logic [lphs_pkg::LETTERS_W-1:0]      letters;
  logic [lphs_pkg::LEN_W-1:0]          len;
  logic [lphs_pkg::SLOT_W-1:0]         iss_slot;
  logic [lphs_pkg::SLOT_W-1:0]         iss_cnt;
  logic [lphs_pkg::SLOT_W-1:0]         chk_slot;
  logic [lphs_pkg::SLOT_W-1:0]         chk_cnt;
  logic                                chk_live;
  logic                                found_free;
  logic [lphs_pkg::SLOT_W-1:0]         free_slot;
  logic [lphs_pkg::SLOTS-1:0]          slot_valid;
  lphs_pkg::outcome_t                  res_outcome;
  logic [lphs_pkg::SLOT_W-1:0]         res_slot;
  logic                                wr_pending;
  lphs_pkg::status_t                   wr_status;

  logic [lphs_pkg::LETTERS_W-1:0]      letters_next;
  logic [lphs_pkg::LEN_W-1:0]          len_next;
  logic [lphs_pkg::LETTER_W-1:0]       code;
  logic [lphs_pkg::SLOT_W-1:0]         home;
  logic                                rd_en;
  logic                                ram_we;
  logic [lphs_pkg::WORD_W-1:0]         ram_wdata;
  logic [lphs_pkg::WORD_W-1:0]         ram_rdata;
  lphs_pkg::status_t                   cur_status;
  logic                                cur_match;
  logic                                cur_free;
  logic                                eff_found;
  logic [lphs_pkg::SLOT_W-1:0]         eff_slot;
  logic                                in_fire;
  logic                                emit_go;

  // key normalization: clamp length, mask letters, pick home slot
  always_comb begin
    if (key_length == '0) begin
      len_next = lphs_pkg::LEN_W'(1);
    end else if (key_length > lphs_pkg::LEN_W'(lphs_pkg::MAX_LETTERS)) begin
      len_next = lphs_pkg::LEN_W'(lphs_pkg::MAX_LETTERS);
    end else begin
      len_next = key_length;
    end
    letters_next = '0;
    code         = '0;
    for (int i = 0; i < lphs_pkg::MAX_LETTERS; i++) begin
      if (lphs_pkg::LEN_W'(i) < len_next) begin
        letters_next[i*lphs_pkg::LETTER_W +: lphs_pkg::LETTER_W] =
          key_letters[i*lphs_pkg::LETTER_W +: lphs_pkg::LETTER_W];
      end
      if (lphs_pkg::LEN_W'(i) == len_next - 1'b1) begin
        code = key_letters[i*lphs_pkg::LETTER_W +: lphs_pkg::LETTER_W];
      end
    end
    home = (code >= lphs_pkg::LETTER_W'(lphs_pkg::SLOTS)) ?
           lphs_pkg::SLOT_W'(code - lphs_pkg::LETTER_W'(lphs_pkg::SLOTS)) :
           lphs_pkg::SLOT_W'(code);
  end

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign rd_en    = (state == S_PROBE) && (iss_cnt != lphs_pkg::SLOT_W'(lphs_pkg::SLOTS));
  assign emit_go  = (state == S_EMIT) && (!out_valid || !out_stall);
  assign ram_we   = emit_go && wr_pending;
  assign ram_wdata = {wr_status, len, letters};

  // examine the slot whose read data arrives this cycle
  always_comb begin
    cur_status = slot_valid[chk_slot] ?
                 lphs_pkg::status_t'(ram_rdata[lphs_pkg::WORD_W-1 -: 2]) :
                 lphs_pkg::ST_NEVER;
    cur_match  = (cur_status == lphs_pkg::ST_OCCUPIED) &&
                 (ram_rdata[lphs_pkg::KEY_W-1:0] == {len, letters});
    cur_free   = (cur_status != lphs_pkg::ST_OCCUPIED);
    eff_found  = found_free || cur_free;
    eff_slot   = found_free ? free_slot : chk_slot;
  end

  lphs_ram #(
    .WIDTH (lphs_pkg::WORD_W),
    .DEPTH (lphs_pkg::SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (res_slot),
    .wdata (ram_wdata),
    .re    (rd_en),
    .raddr (iss_slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      slot_valid <= '0;
      chk_live   <= 1'b0;
      wr_pending <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            act        <= action;
            letters    <= letters_next;
            len        <= len_next;
            iss_slot   <= home;
            iss_cnt    <= '0;
            chk_cnt    <= '0;
            chk_live   <= 1'b0;
            found_free <= 1'b0;
            state      <= S_PROBE;
          end
        end
        S_PROBE: begin
          chk_live <= rd_en;
          chk_slot <= iss_slot;
          if (rd_en) begin
            iss_slot <= lphs_pkg::next_slot(iss_slot);
            iss_cnt  <= iss_cnt + 1'b1;
          end
          if (chk_live) begin
            chk_cnt <= chk_cnt + 1'b1;
            if (!found_free && cur_free) begin
              found_free <= 1'b1;
              free_slot  <= chk_slot;
            end
            if (cur_match || cur_status == lphs_pkg::ST_NEVER ||
                chk_cnt == lphs_pkg::SLOT_W'(lphs_pkg::SLOTS - 1)) begin
              state    <= S_EMIT;
              chk_live <= 1'b0;
              if (act == lphs_pkg::ACT_ADD) begin
                if (cur_match) begin
                  res_outcome <= lphs_pkg::OUT_PRESENT;
                  res_slot    <= chk_slot;
                  wr_pending  <= 1'b0;
                end else if (eff_found) begin
                  res_outcome <= lphs_pkg::OUT_ADDED;
                  res_slot    <= eff_slot;
                  wr_pending  <= 1'b1;
                  wr_status   <= lphs_pkg::ST_OCCUPIED;
                end else begin
                  res_outcome <= lphs_pkg::OUT_FULL;
                  res_slot    <= '0;
                  wr_pending  <= 1'b0;
                end
              end else begin
                if (cur_match) begin
                  res_outcome <= lphs_pkg::OUT_DELETED;
                  res_slot    <= chk_slot;
                  wr_pending  <= 1'b1;
                  wr_status   <= lphs_pkg::ST_TOMB;
                end else begin
                  res_outcome <= lphs_pkg::OUT_NOTFOUND;
                  res_slot    <= '0;
                  wr_pending  <= 1'b0;
                end
              end
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid  <= 1'b1;
            outcome    <= res_outcome;
            slot_index <= res_slot;
            wr_pending <= 1'b0;
            if (wr_pending) begin
              slot_valid[res_slot] <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/lphs_checker.sv */
// port-level checks of the linear probe hash set, bound to the top level
// depends on lphs_pkg and linear_probe_hash_set_top_defines.svh
`include "linear_probe_hash_set_top_defines.svh"

module lphs_port_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           action,
  input logic [lphs_pkg::LETTERS_W-1:0] key_letters,
  input logic [lphs_pkg::LEN_W-1:0]     key_length,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [2:0]                     outcome,
  input logic [lphs_pkg::SLOT_W-1:0]    slot_index
);

  localparam logic [lphs_pkg::SLOT_W-1:0] LAST_SLOT = lphs_pkg::SLOT_W'(lphs_pkg::SLOTS - 1);

  logic no_slot;

  assign no_slot = (outcome == lphs_pkg::OUT_NOTFOUND) || (outcome == lphs_pkg::OUT_FULL);

  `LPHS_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
  `LPHS_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable({outcome, slot_index}))
  `LPHS_ASSERT_NOW(a_outcome_range, out_valid, outcome <= lphs_pkg::OUT_FULL && slot_index <= LAST_SLOT)
  `LPHS_ASSERT_NOW(a_none_slot_zero, out_valid && no_slot, slot_index == '0)

endmodule

bind linear_probe_hash_set_top lphs_port_checker u_lphs_port_checker (.*);

/* verif/lphs_checker.sv */
// result checker for the linear probe hash set: watches both channels, keeps its own
// slot table, predicts each result and compares it with the block's output
// depends on lphs_pkg
module lphs_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           action,
  input  logic [lphs_pkg::LETTERS_W-1:0] key_letters,
  input  logic [lphs_pkg::LEN_W-1:0]     key_length,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [2:0]                     outcome,
  input  logic [lphs_pkg::SLOT_W-1:0]    slot_index,
  output int                             fail_count,
  output int                             pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    lphs_pkg::outcome_t              outcome;
    logic [lphs_pkg::SLOT_W-1:0]     slot;
  } set_result_t;

  lphs_pkg::status_t              slot_state   [lphs_pkg::SLOTS];
  logic [lphs_pkg::LETTERS_W-1:0] slot_letters [lphs_pkg::SLOTS];
  logic [lphs_pkg::LEN_W-1:0]     slot_len     [lphs_pkg::SLOTS];
  set_result_t                    expected_results [$];
  set_result_t                    oldest;

  // applies one add or delete to the slot table and returns its result
  function automatic set_result_t update_set(input logic act,
                                             input logic [lphs_pkg::LETTERS_W-1:0] raw_letters,
                                             input logic [lphs_pkg::LEN_W-1:0] raw_len);
    int                             len;
    int                             home;
    int                             s;
    int                             hit;
    int                             free_s;
    logic [lphs_pkg::LETTERS_W-1:0] letters;
    logic [lphs_pkg::LETTER_W-1:0]  last_code;
    set_result_t                    res;
    len = int'(raw_len);
    if (len == 0) len = 1;
    if (len > lphs_pkg::MAX_LETTERS) len = lphs_pkg::MAX_LETTERS;
    letters   = raw_letters &
                ~({lphs_pkg::LETTERS_W{1'b1}} << (lphs_pkg::LETTER_W * len));
    last_code = letters[lphs_pkg::LETTER_W*(len-1) +: lphs_pkg::LETTER_W];
    home      = (int'(last_code) >= lphs_pkg::SLOTS) ?
                int'(last_code) - lphs_pkg::SLOTS : int'(last_code);
    hit = -1;
    s   = home;
    for (int n = 0; n < lphs_pkg::SLOTS; n++) begin
      if (slot_state[s] == lphs_pkg::ST_OCCUPIED && int'(slot_len[s]) == len &&
          slot_letters[s] == letters) begin
        hit = s;
        break;
      end
      if (slot_state[s] == lphs_pkg::ST_NEVER) break;
      s = (s + 1) % lphs_pkg::SLOTS;
    end
    free_s = -1;
    s      = home;
    for (int n = 0; n < lphs_pkg::SLOTS; n++) begin
      if (slot_state[s] != lphs_pkg::ST_OCCUPIED) begin
        free_s = s;
        break;
      end
      s = (s + 1) % lphs_pkg::SLOTS;
    end
    res.slot = '0;
    if (act == lphs_pkg::ACT_ADD) begin
      if (hit >= 0) begin
        res.outcome = lphs_pkg::OUT_PRESENT;
        res.slot    = lphs_pkg::SLOT_W'(hit);
      end else if (free_s >= 0) begin
        slot_state[free_s]   = lphs_pkg::ST_OCCUPIED;
        slot_letters[free_s] = letters;
        slot_len[free_s]     = lphs_pkg::LEN_W'(len);
        res.outcome          = lphs_pkg::OUT_ADDED;
        res.slot             = lphs_pkg::SLOT_W'(free_s);
      end else begin
        res.outcome = lphs_pkg::OUT_FULL;
      end
    end else if (hit >= 0) begin
      slot_state[hit] = lphs_pkg::ST_TOMB;
      res.outcome     = lphs_pkg::OUT_DELETED;
      res.slot        = lphs_pkg::SLOT_W'(hit);
    end else begin
      res.outcome = lphs_pkg::OUT_NOTFOUND;
    end
    return res;
  endfunction

  task automatic note_mismatch(input string field, input int exp_v, input int act_v);
    $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lphs_pkg::SLOTS; i++) slot_state[i] = lphs_pkg::ST_NEVER;
      expected_results.delete();
      pending = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: outcome %0d, slot_index %0d",
                 outcome, slot_index);
          fail_count++;
        end else begin
          oldest = expected_results.pop_front();
          if (outcome !== oldest.outcome)
            note_mismatch("outcome", int'(oldest.outcome), int'(outcome));
          if (slot_index !== oldest.slot)
            note_mismatch("slot_index", int'(oldest.slot), int'(slot_index));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(update_set(action, key_letters, key_length));
      pending = expected_results.size();
    end
  end

endmodule

/* verif/tb_linear_probe_hash_set_top.sv */
// testbench top for the linear probe hash set: clock, reset, key stimulus and
// random input gaps and output stalls; the verdict comes from the failure count of lphs_checker
// depends on lphs_pkg, lphs_checker and linear_probe_hash_set_top
module tb_linear_probe_hash_set_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS  = 212;
  localparam int POOL_SIZE    = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [lphs_pkg::LETTERS_W-1:0] letters;
    logic [lphs_pkg::LEN_W-1:0]     len;
  } hash_key_t;

  logic                           clk         = 1'b0;
  logic                           rst         = 1'b1;
  logic                           in_valid    = 1'b0;
  logic                           action      = lphs_pkg::ACT_ADD;
  logic [lphs_pkg::LETTERS_W-1:0] key_letters = '0;
  logic [lphs_pkg::LEN_W-1:0]     key_length  = 4'd1;
  logic                           out_stall   = 1'b0;
  logic                           in_stall;
  logic                           out_valid;
  logic [2:0]                     outcome;
  logic [lphs_pkg::SLOT_W-1:0]    slot_index;

  int        fail_count;
  int        pending;
  int        cycle_count   = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;
  int        add_pct       = 80;
  hash_key_t key_pool [POOL_SIZE];

  linear_probe_hash_set_top u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .key_letters (key_letters),
    .key_length  (key_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .outcome     (outcome),
    .slot_index  (slot_index)
  );

  lphs_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .key_letters (key_letters),
    .key_length  (key_length),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .outcome     (outcome),
    .slot_index  (slot_index),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [lphs_pkg::LETTERS_W-1:0] random_letters();
    return lphs_pkg::LETTERS_W'({$urandom, $urandom});
  endfunction

  // short keys whose last letter mostly lands near the wrap of the table
  function automatic hash_key_t make_key();
    hash_key_t k;
    int        len;
    int        pick;
    int        last_code;
    len  = ($urandom_range(3) == 0) ? $urandom_range(10, 1) : $urandom_range(3, 1);
    pick = $urandom_range(5);
    if ($urandom_range(1))
      last_code = $urandom_range(31);
    else
      last_code = (pick < 2) ? 24 + pick : ((pick < 4) ? pick - 2 : pick + 22);
    k.letters = random_letters() &
                ~({lphs_pkg::LETTERS_W{1'b1}} << (lphs_pkg::LETTER_W * len));
    k.letters[lphs_pkg::LETTER_W*(len-1) +: lphs_pkg::LETTER_W] =
      lphs_pkg::LETTER_W'(last_code);
    k.len = lphs_pkg::LEN_W'(len);
    return k;
  endfunction

  // entered and left at a falling edge; valid stays high between back-to-back transfers
  task automatic send_item(input logic act, input logic [lphs_pkg::LETTERS_W-1:0] letters,
                           input logic [lphs_pkg::LEN_W-1:0] len);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    action      <= act;
    key_letters <= letters;
    key_length  <= len;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // same key, sometimes with junk above its length or an aliased length code
  task automatic send_pool_key(input logic act, input hash_key_t k);
    logic [lphs_pkg::LETTERS_W-1:0] letters;
    logic [lphs_pkg::LEN_W-1:0]     len;
    letters = k.letters;
    len     = k.len;
    if ($urandom_range(3) == 0) letters |= random_letters() << (lphs_pkg::LETTER_W * k.len);
    if (k.len == 1 && $urandom_range(1)) len = '0;
    if (k.len == lphs_pkg::MAX_LETTERS && $urandom_range(1))
      len = lphs_pkg::LEN_W'($urandom_range(15, 11));
    send_item(act, letters, len);
  endtask

  task automatic random_item();
    if ($urandom_range(99) < 8)
      send_item(1'($urandom_range(1)), random_letters(), lphs_pkg::LEN_W'($urandom_range(15)));
    else
      send_pool_key(($urandom_range(99) < add_pct) ? lphs_pkg::ACT_ADD : lphs_pkg::ACT_DEL,
                    key_pool[$urandom_range(POOL_SIZE - 1)]);
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = make_key();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(lphs_pkg::ACT_ADD, '0, 4'd1);
    send_item(lphs_pkg::ACT_ADD, '0, 4'd1);
    send_item(lphs_pkg::ACT_ADD, '0, 4'd0);
    send_item(lphs_pkg::ACT_ADD, {10{5'd25}}, 4'd10);
    send_item(lphs_pkg::ACT_ADD, {10{5'd25}}, 4'd15);
    send_item(lphs_pkg::ACT_ADD, lphs_pkg::LETTERS_W'(31), 4'd1);
    send_item(lphs_pkg::ACT_ADD, lphs_pkg::LETTERS_W'(26), 4'd1);
    send_item(lphs_pkg::ACT_ADD, {{40{1'b1}}, 5'd25, 5'd3}, 4'd2);
    send_item(lphs_pkg::ACT_DEL, '0, 4'd1);
    send_item(lphs_pkg::ACT_DEL, '0, 4'd1);
    send_item(lphs_pkg::ACT_ADD, lphs_pkg::LETTERS_W'(26), 4'd1);
    send_item(lphs_pkg::ACT_ADD, lphs_pkg::LETTERS_W'({5'd0, 5'd7}), 4'd2);
    send_item(lphs_pkg::ACT_DEL, lphs_pkg::LETTERS_W'({5'd4, 5'd2}), 4'd2);
    send_item(lphs_pkg::ACT_ADD, {lphs_pkg::LETTERS_W{1'b1}}, 4'd15);
    send_item(lphs_pkg::ACT_DEL, '0, 4'd10);
    send_item(lphs_pkg::ACT_DEL, lphs_pkg::LETTERS_W'({5'd25, 5'd3}), 4'd2);
    send_item(lphs_pkg::ACT_ADD, lphs_pkg::LETTERS_W'(31), 4'd1);
    send_item(lphs_pkg::ACT_ADD, '0, 4'd2);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 53;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 53;
        end
        default: begin
          send_idle_pct = 32;
          stall_pct     = 32;
        end
      endcase
      // alternate filling and draining so the table goes full and back
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        add_pct = ((i / 50) % 2 == 0) ? 80 : 35;
        random_item();
      end
    end

    in_valid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* linear_probe_hash_set_top.f */
+incdir+rtl
rtl/lphs_pkg.sv
rtl/lphs_ram.sv
rtl/linear_probe_hash_set_top.sv
rtl/lphs_checker.sv
verif/lphs_checker.sv
verif/tb_linear_probe_hash_set_top.sv
